/* sv/multiplexed_led_pwm_scanner_unit_assert.svh */
// ---------------------------------------------------------------------------
// LED PWM scanner assertion macros
// Concurrent assertion helpers used by the scanner RTL; empty under SYNTH.
// ---------------------------------------------------------------------------
`ifndef MULTIPLEXED_LED_PWM_SCANNER_UNIT_ASSERT_SVH
`define MULTIPLEXED_LED_PWM_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTH

// expr must hold at every clock edge outside reset
`define MLPS_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("scanner assertion failed");

// cons must hold in the same cycle as ante
`define MLPS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// cons must hold in the cycle after ante
`define MLPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`else

`define MLPS_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define MLPS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define MLPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/mlps_pkg.sv */
// ---------------------------------------------------------------------------
// LED PWM scanner package
// Shared sizes, codes, types and helper functions of the scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package mlps_pkg;

   localparam int ROWS    = 8;
   localparam int COLUMNS = 16;
   localparam int LEVELS  = 15;
   localparam int COLORS  = 3;

   localparam int LEVEL_W   = 4;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int ROW_CNT_W = $clog2(ROWS + 1);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int IN_LVL_W  = 8;
   localparam int CSR_W     = 4;

   localparam logic [LEVEL_W-1:0]   MAX_INTENSITY   = 4'd15;
   localparam logic [CSR_W-1:0]     SCAN_ROWS_RESET = 4'd7;
   localparam logic [LEVEL_W-1:0]   LEVEL_LIMIT     = LEVEL_W'(LEVELS);
   localparam logic [ROW_CNT_W-1:0] ROW_LIMIT       = ROW_CNT_W'(ROWS);

   typedef enum logic {
      FUNC_SET  = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      COLOR_RED   = 2'd0,
      COLOR_GREEN = 2'd1,
      COLOR_BLUE  = 2'd2
   } color_type;

   typedef logic [COLUMNS-1:0][LEVEL_W-1:0] plane_type;
   typedef plane_type [COLORS-1:0]          row_data_type;

   typedef struct packed {
      logic             rd_en;
      logic [ROW_W-1:0] rd_addr;
      logic             wr_en;
      logic [ROW_W-1:0] wr_addr;
      row_data_type     wr_data;
   } mem_cmd_type;

   typedef struct packed {
      logic [ROW_W-1:0]   active_row;
      logic [ROW_W-1:0]   previous_row;
      logic [LEVEL_W-1:0] level;
   } scan_state_type;

   function automatic logic [LEVEL_W-1:0] sat_level(input logic [IN_LVL_W-1:0] v);
      logic [LEVEL_W-1:0] r;
      r = (v >= IN_LVL_W'(MAX_INTENSITY)) ? MAX_INTENSITY : v[LEVEL_W-1:0];
      return r;
   endfunction

   // thermometer compare: column lit while the plane index is below its level
   function automatic logic [COLUMNS-1:0] plane_word(input plane_type p,
                                                     input logic [LEVEL_W-1:0] lvl);
      logic [COLUMNS-1:0] w;
      for (int c = 0; c < COLUMNS; c++) begin
         w[c] = (lvl < p[c]);
      end
      return w;
   endfunction

endpackage

`default_nettype wire

/* sv/mlps_frame_mem.sv */
// ---------------------------------------------------------------------------
// LED PWM scanner frame store
// One row of all three colors per entry; registered read, per-row valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

`include "multiplexed_led_pwm_scanner_unit_assert.svh"

module mlps_frame_mem
   import mlps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mem_cmd_type  mem_cmd,
   output row_data_type rd_data
);

   row_data_type     store_ff [ROWS];
   row_data_type     rd_data_ff;
   logic             rd_valid_ff;
   logic [ROWS-1:0]  valid_ff;
   logic [ROWS-1:0]  valid_in;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         store_ff[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= store_ff[mem_cmd.rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (mem_cmd.wr_en) begin
         valid_in[mem_cmd.wr_addr] = 1'b1;
      end
   end

   // rows never written since reset read back as all off
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (mem_cmd.rd_en) begin
            rd_valid_ff <= valid_ff[mem_cmd.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

   `MLPS_ASSERT_ALWAYS(a_no_rd_wr_overlap, clock, reset, !(mem_cmd.rd_en && mem_cmd.wr_en))
   `MLPS_ASSERT_NEXT(a_wr_sets_valid, clock, reset, mem_cmd.wr_en, valid_ff[$past(mem_cmd.wr_addr)])

endmodule

`default_nettype wire

/* sv/mlps_scan_ctrl.sv */
// ---------------------------------------------------------------------------
// LED PWM scanner scan counters
// PWM level and row counters plus the scan length register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "multiplexed_led_pwm_scanner_unit_assert.svh"

module mlps_scan_ctrl
   import mlps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_W-1:0]     csr_write_data,
   input  logic                 advance,
   output logic [ROW_W-1:0]     next_row,
   output scan_state_type       scan_state
);

   logic [CSR_W-1:0]     scan_rows_ff;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ROW_W-1:0]     last_row_ff, last_row_in;
   logic [ROW_CNT_W-1:0] limit;
   logic [ROW_CNT_W-1:0] row_inc;
   logic [LEVEL_W-1:0]   level_inc;
   logic [ROW_W-1:0]     row_wrap;
   logic                 wrap;

   // zero scans one row, anything above the array scans all rows
   always_comb begin
      if (scan_rows_ff == '0) begin
         limit = ROW_CNT_W'(1);
      end else if (scan_rows_ff > CSR_W'(ROW_LIMIT)) begin
         limit = ROW_LIMIT;
      end else begin
         limit = ROW_CNT_W'(scan_rows_ff);
      end
   end

   assign level_inc = level_ff + LEVEL_W'(1);
   assign wrap      = (level_inc >= LEVEL_LIMIT);
   assign row_inc   = ROW_CNT_W'(row_ff) + ROW_CNT_W'(1);
   assign row_wrap  = (row_inc >= limit) ? '0 : row_inc[ROW_W-1:0];
   assign next_row  = wrap ? row_wrap : row_ff;

   always_comb begin
      level_in    = level_ff;
      row_in      = row_ff;
      last_row_in = last_row_ff;
      if (advance) begin
         level_in = wrap ? '0 : level_inc;
         if (wrap) begin
            last_row_in = row_ff;
            row_in      = row_wrap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_rows_ff <= SCAN_ROWS_RESET;
         level_ff     <= '0;
         row_ff       <= '0;
         last_row_ff  <= '0;
      end else begin
         if (csr_write_en) begin
            scan_rows_ff <= csr_write_data;
         end
         level_ff    <= level_in;
         row_ff      <= row_in;
         last_row_ff <= last_row_in;
      end
   end

   assign scan_state.active_row   = row_ff;
   assign scan_state.previous_row = last_row_ff;
   assign scan_state.level        = level_ff;

   `MLPS_ASSERT_ALWAYS(a_level_in_range, clock, reset, level_ff < LEVEL_LIMIT)
   `MLPS_ASSERT_NEXT(a_prev_row_holds, clock, reset, !(advance && wrap), $stable(last_row_ff))

endmodule

`default_nettype wire

/* sv/multiplexed_led_pwm_scanner_unit.sv */
// ---------------------------------------------------------------------------
// Multiplexed LED PWM scanner
// Frame store and scan engine for a row-multiplexed RGB LED array.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken on the rising edge where start is high and busy
//   is low. req_func selects a set (store one LED's three levels, saturated
//   at 15) or a tick (advance the PWM level; on wrap advance the row).
//   The frame store is read in the cycle after the transaction is taken and
//   a set writes the merged row back in the same cycle, so busy is high for
//   exactly one cycle and start is not taken while busy, set or tick alike.
//   A tick returns one result: rsp_strobe is high for one cycle, the cycle
//   after busy, with the row numbers, level and green, blue, red column
//   words. The receiver cannot stall; the words hold until the next result.
//   A set returns nothing.
//   csr_write_en / csr_write_data load the scan length; write it only while
//   the block is idle.
//   Reset clears the counters, sets the scan length to 7 and marks every row
//   of the frame store as off at once through per-row valid bits, so there
//   is no clearing pass and start is taken right after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "multiplexed_led_pwm_scanner_unit_assert.svh"

module multiplexed_led_pwm_scanner_unit
   import mlps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [1:0]          req_panel,
   input  logic [1:0]          req_row_in,
   input  logic [1:0]          req_column_in,
   input  logic [IN_LVL_W-1:0] req_red_level,
   input  logic [IN_LVL_W-1:0] req_green_level,
   input  logic [IN_LVL_W-1:0] req_blue_level,
   input  logic                csr_write_en,
   input  logic [CSR_W-1:0]    csr_write_data,
   output logic                rsp_strobe,
   output logic [ROW_W-1:0]    rsp_active_row,
   output logic [ROW_W-1:0]    rsp_previous_row,
   output logic [LEVEL_W-1:0]  rsp_pwm_level,
   output logic [COLUMNS-1:0]  rsp_word_green,
   output logic [COLUMNS-1:0]  rsp_word_blue,
   output logic [COLUMNS-1:0]  rsp_word_red
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic               func_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   col_ff;
   logic [LEVEL_W-1:0] red_ff, green_ff, blue_ff;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [ROW_W-1:0]   rsp_active_row_ff, rsp_previous_row_ff;
   logic [LEVEL_W-1:0] rsp_pwm_level_ff;
   logic [COLUMNS-1:0] rsp_word_green_ff, rsp_word_blue_ff, rsp_word_red_ff;

   logic               accept;
   logic               advance;
   logic [ROW_W-1:0]   set_row;
   logic [ROW_W-1:0]   next_row;
   scan_state_type     scan_state;
   mem_cmd_type        mem_cmd;
   row_data_type       rd_data;
   row_data_type       merged;

   assign busy    = (state_ff == ST_EXEC);
   assign accept  = start && !busy;
   assign advance = accept && (req_func == FUNC_TICK);
   assign set_row = {req_panel[0], req_row_in};

   mlps_scan_ctrl u_scan (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .advance        (advance),
      .next_row       (next_row),
      .scan_state     (scan_state)
   );

   always_comb begin
      merged                      = rd_data;
      merged[COLOR_RED][col_ff]   = red_ff;
      merged[COLOR_GREEN][col_ff] = green_ff;
      merged[COLOR_BLUE][col_ff]  = blue_ff;
   end

   // a tick reads the row it is about to show, a set reads the row to merge
   always_comb begin
      mem_cmd.rd_en   = accept;
      mem_cmd.rd_addr = (req_func == FUNC_TICK) ? next_row : set_row;
      mem_cmd.wr_en   = busy && (func_ff == FUNC_SET);
      mem_cmd.wr_addr = row_ff;
      mem_cmd.wr_data = merged;
   end

   mlps_frame_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = (func_ff == FUNC_TICK);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         row_ff   <= set_row;
         col_ff   <= COL_W'({req_panel[1], req_column_in});
         red_ff   <= sat_level(req_red_level);
         green_ff <= sat_level(req_green_level);
         blue_ff  <= sat_level(req_blue_level);
      end
      if (rsp_strobe_in) begin
         rsp_active_row_ff   <= scan_state.active_row;
         rsp_previous_row_ff <= scan_state.previous_row;
         rsp_pwm_level_ff    <= scan_state.level;
         rsp_word_green_ff   <= plane_word(rd_data[COLOR_GREEN], scan_state.level);
         rsp_word_blue_ff    <= plane_word(rd_data[COLOR_BLUE], scan_state.level);
         rsp_word_red_ff     <= plane_word(rd_data[COLOR_RED], scan_state.level);
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_active_row   = rsp_active_row_ff;
   assign rsp_previous_row = rsp_previous_row_ff;
   assign rsp_pwm_level    = rsp_pwm_level_ff;
   assign rsp_word_green   = rsp_word_green_ff;
   assign rsp_word_blue    = rsp_word_blue_ff;
   assign rsp_word_red     = rsp_word_red_ff;

   `MLPS_ASSERT_NEXT(a_accept_sets_busy, clock, reset, accept, busy)
   `MLPS_ASSERT_IMPLY(a_strobe_after_tick, clock, reset, rsp_strobe_ff, $past(busy && (func_ff == FUNC_TICK)))

endmodule

`default_nettype wire
